@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define C8_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define C8_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/c8_pkg.sv @@
package c8_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int STACK_DEPTH = 16;
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;
    localparam int PROG_START  = 512;
    localparam int FONT_START  = 80;
    localparam int FONT_BYTES  = 80;

    localparam int ADDR_W     = $clog2(MEM_BYTES);
    localparam int ROW_W      = $clog2(SCREEN_H);
    localparam int COL_W      = $clog2(SCREEN_W);
    localparam int SP_W       = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W     = $clog2(STACK_DEPTH);
    localparam int FONT_IDX_W = $clog2(FONT_BYTES);
    localparam int CFG_IDX_W  = 3;

    localparam logic [2:0] OP_EXEC    = 3'd0;
    localparam logic [2:0] OP_TICK    = 3'd1;
    localparam logic [2:0] OP_LOAD    = 3'd2;
    localparam logic [2:0] OP_REFRESH = 3'd3;
    localparam logic [2:0] OP_ROW     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WAIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOGIC_CLEARS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BULK_INDEX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_VX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_VX      = 3'd5;

    localparam logic [1:0] PH_FREE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    localparam logic [4:0] NO_KEY   = 5'd16;
    localparam logic [3:0] FLAG_REG = 4'hF;

    localparam logic [3:0] OPC_SYS  = 4'h0;
    localparam logic [3:0] OPC_JP   = 4'h1;
    localparam logic [3:0] OPC_CALL = 4'h2;
    localparam logic [3:0] OPC_SEQ  = 4'h3;
    localparam logic [3:0] OPC_SNE  = 4'h4;
    localparam logic [3:0] OPC_SER  = 4'h5;
    localparam logic [3:0] OPC_LD   = 4'h6;
    localparam logic [3:0] OPC_ADD  = 4'h7;
    localparam logic [3:0] OPC_ALU  = 4'h8;
    localparam logic [3:0] OPC_SNER = 4'h9;
    localparam logic [3:0] OPC_LDI  = 4'hA;
    localparam logic [3:0] OPC_JPV  = 4'hB;
    localparam logic [3:0] OPC_RND  = 4'hC;
    localparam logic [3:0] OPC_DRW  = 4'hD;
    localparam logic [3:0] OPC_KEY  = 4'hE;
    localparam logic [3:0] OPC_MISC = 4'hF;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] LO_RET  = 8'hEE;
    localparam logic [7:0] LO_CLS  = 8'hE0;
    localparam logic [7:0] LO_SKP  = 8'h9E;
    localparam logic [7:0] LO_SKNP = 8'hA1;
    localparam logic [7:0] LO_GDT  = 8'h07;
    localparam logic [7:0] LO_KEY  = 8'h0A;
    localparam logic [7:0] LO_SDT  = 8'h15;
    localparam logic [7:0] LO_SST  = 8'h18;
    localparam logic [7:0] LO_ADI  = 8'h1E;
    localparam logic [7:0] LO_FNT  = 8'h29;
    localparam logic [7:0] LO_BCD  = 8'h33;
    localparam logic [7:0] LO_STR  = 8'h55;
    localparam logic [7:0] LO_LDR  = 8'h65;

    localparam logic [7:0] HEX_FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] off;
        off = a - ADDR_W'(FONT_START);
        if (a >= ADDR_W'(FONT_START) && off < ADDR_W'(FONT_BYTES)) begin
            return HEX_FONT[off[FONT_IDX_W-1:0]];
        end
        return 8'h00;
    endfunction

endpackage

@@ rtl/c8_req_if.sv @@
interface c8_req_if import c8_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        op;
    logic [ADDR_W-1:0] load_addr;
    logic [7:0]        load_data;
    logic [15:0]       keypad;
    logic [7:0]        rand_byte;
    logic [ROW_W-1:0]  row_sel;

    modport source (output valid, op, load_addr, load_data, keypad, rand_byte, row_sel,
                    input ready);
    modport sink (input valid, op, load_addr, load_data, keypad, rand_byte, row_sel,
                  output ready);
endinterface

@@ rtl/c8_rsp_if.sv @@
interface c8_rsp_if import c8_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SCREEN_W-1:0] row_pixels;
    logic [ADDR_W-1:0]   prog_counter;
    logic                sound_on;
    logic                blocked;
    logic                stack_fault;

    modport source (output valid, row_pixels, prog_counter, sound_on, blocked, stack_fault,
                    input ready);
    modport sink (input valid, row_pixels, prog_counter, sound_on, blocked, stack_fault,
                  output ready);
endinterface

@@ rtl/chip8_cpu_core_unit.sv @@
// CHIP-8 interpreter core. Program memory, the V registers and the frame buffer each live
// in a synchronous RAM; a sequencer fetches the two opcode bytes, reads VX and VY, and then
// executes. After reset a clearing pass over every address loads zeros and the hex font into
// program memory, during which no word is accepted (configuration writes still are).
// Each RAM has a single read port with a registered output, so its reads are sequenced
// through the states. Each word yields one result word, held in an output register, and
// the next word is accepted as that result is taken.
module chip8_cpu_core_unit import c8_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                 i_cfg_data,
    c8_req_if.sink               i_req,
    c8_rsp_if.source             o_rsp
);
    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_ROW, S_F1, S_F2, S_F3, S_F4, S_EXEC, S_WFLAG,
        S_DM, S_DF, S_DW, S_DEND, S_BCD, S_SRD, S_SWR, S_LRD, S_LWR, S_RESP
    } t_state;

    t_state r_state;
    logic [ADDR_W-1:0]   r_clr;
    logic [2:0]          r_op;
    logic [15:0]         r_keys;
    logic [7:0]          r_rand;
    logic [7:0]          r_hi, r_lo, r_vx, r_vy;
    logic [ADDR_W-1:0]   r_pc;
    logic [15:0]         r_idx;
    logic [SP_W-1:0]     r_sp;
    logic [ADDR_W-1:0]   r_stack [STACK_DEPTH];
    logic [7:0]          r_delay, r_sound;
    logic [1:0]          r_phase;
    logic [4:0]          r_held;
    logic                r_cfg_dw, r_cfg_lc, r_cfg_bi, r_cfg_clip, r_cfg_sh, r_cfg_jv;
    logic [15:0]         r_vvalid;
    logic [SCREEN_H-1:0] r_fvalid;
    logic                r_vq_ok, r_fq_ok;
    logic [3:0]          r_i;
    logic [7:0]          r_bits, r_flag;
    logic                r_coll, r_blk, r_fault;
    logic [SCREEN_W-1:0] r_res_row;
    logic                r_o_valid;
    logic [SCREEN_W-1:0] r_o_row;
    logic [ADDR_W-1:0]   r_o_pc;
    logic                r_o_sound, r_o_blk, r_o_fault;

    logic                m_we;
    logic [ADDR_W-1:0]   m_waddr, m_raddr;
    logic [7:0]          m_wdata, m_q;
    logic                v_we;
    logic [3:0]          v_waddr, v_raddr;
    logic [7:0]          v_wdata, v_rd, v_q;
    logic                f_we;
    logic [ROW_W-1:0]    f_waddr, f_raddr;
    logic [SCREEN_W-1:0] f_wdata, f_rd, f_q;

    logic                in_rdy, accept;
    logic [3:0]          opc, xr, alu;
    logic [ADDR_W-1:0]   nnn, pc2, pc4, bulk_addr;
    logic [7:0]          shsrc;
    logic [8:0]          sum9;
    logic                e_vwe, e_fwe;
    logic [3:0]          e_vaddr;
    logic [7:0]          e_vdata, e_fval;
    logic [15:0]         idx_sum;
    logic                key_any, key_down;
    logic [3:0]          key_low;
    logic [SIDX_W-1:0]   sp_top, sp_dec;
    logic [SP_W-1:0]     sp_m1;
    logic [7:0]          bcd_h, bcd_r, bcd_t, bcd_o, bcd_d;
    logic [15:0]         bcd_m;
    logic [SCREEN_W-1:0] spr_base, spr_mask;
    logic [COL_W-1:0]    spr_x;
    logic [ROW_W-1:0]    d_row;
    logic                d_last;

    c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_q)
    );
    c8_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rd)
    );
    c8_ram #(.WIDTH(SCREEN_W), .DEPTH(SCREEN_H)) u_frame (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rd)
    );

    assign v_q    = r_vq_ok ? v_rd : 8'h00;
    assign f_q    = r_fq_ok ? f_rd : '0;
    assign in_rdy = (r_state == S_IDLE) && (!r_o_valid || o_rsp.ready);
    assign accept = i_req.valid && in_rdy;
    assign i_req.ready = in_rdy;

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.row_pixels   = r_o_row;
    assign o_rsp.prog_counter = r_o_pc;
    assign o_rsp.sound_on     = r_o_sound;
    assign o_rsp.blocked      = r_o_blk;
    assign o_rsp.stack_fault  = r_o_fault;

    assign opc       = r_hi[7:4];
    assign xr        = r_hi[3:0];
    assign alu       = r_lo[3:0];
    assign nnn       = {xr, r_lo};
    assign pc2       = r_pc + ADDR_W'(2);
    assign pc4       = r_pc + ADDR_W'(4);
    assign bulk_addr = r_idx[ADDR_W-1:0] + ADDR_W'(r_i);
    assign shsrc     = r_cfg_sh ? r_vx : r_vy;
    assign sum9      = {1'b0, r_vx} + {1'b0, r_vy};
    assign idx_sum   = r_idx + 16'(r_vx);
    assign key_down  = (r_vx < 8'd16) && r_keys[r_vx[3:0]];
    assign sp_top    = r_sp[SIDX_W-1:0];
    assign sp_m1     = r_sp - SP_W'(1);
    assign sp_dec    = sp_m1[SIDX_W-1:0];

    always_comb begin
        key_any = |r_keys;
        key_low = 4'h0;
        for (int k = 15; k >= 0; k--) begin
            if (r_keys[k]) begin
                key_low = 4'(k);
            end
        end
    end

    always_comb begin
        if (r_vx >= 8'd200) begin
            bcd_h = 8'd2;
        end else if (r_vx >= 8'd100) begin
            bcd_h = 8'd1;
        end else begin
            bcd_h = 8'd0;
        end
        bcd_r = r_vx - 8'(bcd_h * 8'd100);
        bcd_m = 16'(bcd_r) * 16'd205;
        bcd_t = 8'(bcd_m >> 11);
        bcd_o = bcd_r - 8'(bcd_t * 8'd10);
        case (r_i)
            4'd0:    bcd_d = bcd_h;
            4'd1:    bcd_d = bcd_t;
            default: bcd_d = bcd_o;
        endcase
    end

    assign spr_base = {r_bits, {(SCREEN_W - 8){1'b0}}};
    assign spr_x    = r_vx[COL_W-1:0];
    assign spr_mask = r_cfg_clip ? (spr_base >> spr_x)
                    : ((spr_base >> spr_x) | (spr_base << (7'(SCREEN_W) - 7'(spr_x))));
    assign d_row    = r_vy[ROW_W-1:0] + ROW_W'(r_i);
    assign d_last   = ({1'b0, r_i} + 5'd1 == {1'b0, alu})
                   || (r_cfg_clip && ({1'b0, r_vy[ROW_W-1:0]} + 6'(r_i) == 6'(SCREEN_H - 1)));

    always_comb begin
        e_vwe   = 1'b0;
        e_vaddr = xr;
        e_vdata = 8'h00;
        e_fwe   = 1'b0;
        e_fval  = 8'h00;
        unique case (opc)
            OPC_LD: begin
                e_vwe = 1'b1; e_vdata = r_lo;
            end
            OPC_ADD: begin
                e_vwe = 1'b1; e_vdata = r_vx + r_lo;
            end
            OPC_RND: begin
                e_vwe = 1'b1; e_vdata = r_rand & r_lo;
            end
            OPC_ALU: begin
                case (alu)
                    ALU_MOV: begin e_vwe = 1'b1; e_vdata = r_vy; end
                    ALU_OR:  begin e_vwe = 1'b1; e_vdata = r_vx | r_vy; e_fwe = r_cfg_lc; end
                    ALU_AND: begin e_vwe = 1'b1; e_vdata = r_vx & r_vy; e_fwe = r_cfg_lc; end
                    ALU_XOR: begin e_vwe = 1'b1; e_vdata = r_vx ^ r_vy; e_fwe = r_cfg_lc; end
                    ALU_ADD: begin
                        e_vwe = 1'b1; e_vdata = sum9[7:0]; e_fwe = 1'b1;
                        e_fval = {7'b0, sum9[8]};
                    end
                    ALU_SUB: begin
                        e_vwe = 1'b1; e_vdata = r_vx - r_vy; e_fwe = 1'b1;
                        e_fval = {7'b0, r_vx >= r_vy};
                    end
                    ALU_SHR: begin
                        e_vwe = 1'b1; e_vdata = shsrc >> 1; e_fwe = 1'b1;
                        e_fval = {7'b0, shsrc[0]};
                    end
                    ALU_SBN: begin
                        e_vwe = 1'b1; e_vdata = r_vy - r_vx; e_fwe = 1'b1;
                        e_fval = {7'b0, r_vy >= r_vx};
                    end
                    ALU_SHL: begin
                        e_vwe = 1'b1; e_vdata = shsrc << 1; e_fwe = 1'b1;
                        e_fval = {7'b0, shsrc[7]};
                    end
                    default: ;
                endcase
            end
            OPC_MISC: begin
                case (r_lo)
                    LO_GDT: begin e_vwe = 1'b1; e_vdata = r_delay; end
                    LO_KEY: begin
                        e_vwe   = (r_held != NO_KEY) && !r_keys[r_held[3:0]];
                        e_vdata = {3'b0, r_held};
                    end
                    LO_ADI: begin
                        e_vwe = idx_sum > 16'h1000; e_vaddr = FLAG_REG; e_vdata = 8'h01;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        m_we    = 1'b0;
        m_waddr = i_req.load_addr;
        m_wdata = i_req.load_data;
        m_raddr = r_pc;
        v_we    = 1'b0;
        v_waddr = FLAG_REG;
        v_wdata = r_flag;
        v_raddr = xr;
        f_we    = 1'b0;
        f_waddr = d_row;
        f_wdata = f_q ^ spr_mask;
        f_raddr = d_row;
        unique case (r_state)
            S_CLEAR: begin
                m_we = 1'b1; m_waddr = r_clr; m_wdata = font_byte(r_clr);
            end
            S_IDLE: begin
                m_we    = accept && (i_req.op == OP_LOAD);
                f_raddr = i_req.row_sel;
            end
            S_F1: m_raddr = r_pc + ADDR_W'(1);
            S_F3: begin
                if (opc == OPC_JPV) begin
                    v_raddr = r_cfg_jv ? xr : 4'h0;
                end else begin
                    v_raddr = r_lo[7:4];
                end
            end
            S_EXEC: begin
                v_we = e_vwe; v_waddr = e_vaddr; v_wdata = e_vdata;
            end
            S_WFLAG: v_we = 1'b1;
            S_DM:    m_raddr = bulk_addr;
            S_DW:    f_we = 1'b1;
            S_DEND: begin
                v_we = 1'b1; v_wdata = {7'b0, r_coll};
            end
            S_BCD: begin
                m_we = 1'b1; m_waddr = bulk_addr; m_wdata = bcd_d;
            end
            S_SRD: v_raddr = r_i;
            S_SWR: begin
                m_we = 1'b1; m_waddr = bulk_addr; m_wdata = v_q;
            end
            S_LRD: m_raddr = bulk_addr;
            S_LWR: begin
                v_we = 1'b1; v_waddr = r_i; v_wdata = m_q;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_vq_ok <= r_vvalid[v_raddr];
        r_fq_ok <= r_fvalid[f_raddr];
        if (v_we) begin
            r_vvalid[v_waddr] <= 1'b1;
        end
        if (f_we) begin
            r_fvalid[f_waddr] <= 1'b1;
        end
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DISPLAY_WAIT: r_cfg_dw   <= i_cfg_data;
                CFG_LOGIC_CLEARS: r_cfg_lc   <= i_cfg_data;
                CFG_BULK_INDEX:   r_cfg_bi   <= i_cfg_data;
                CFG_CLIP:         r_cfg_clip <= i_cfg_data;
                CFG_SHIFT_VX:     r_cfg_sh   <= i_cfg_data;
                CFG_JUMP_VX:      r_cfg_jv   <= i_cfg_data;
                default: ;
            endcase
        end
        if (r_o_valid && o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                r_clr <= r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(MEM_BYTES - 1)) begin
                    r_state <= S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    r_op      <= i_req.op;
                    r_keys    <= i_req.keypad;
                    r_rand    <= i_req.rand_byte;
                    r_res_row <= '0;
                    r_blk     <= 1'b0;
                    r_fault   <= 1'b0;
                    case (i_req.op)
                        OP_EXEC: r_state <= S_F1;
                        OP_TICK: begin
                            if (r_delay != 8'd0) r_delay <= r_delay - 8'd1;
                            if (r_sound != 8'd0) r_sound <= r_sound - 8'd1;
                            r_state <= S_RESP;
                        end
                        OP_REFRESH: begin
                            if (r_cfg_dw && r_phase == PH_WAIT) r_phase <= PH_DONE;
                            r_state <= S_RESP;
                        end
                        OP_ROW:  r_state <= S_ROW;
                        default: r_state <= S_RESP;
                    endcase
                end
            end
            S_ROW: begin
                r_res_row <= f_q;
                r_state   <= S_RESP;
            end
            S_F1: begin
                r_hi    <= m_q;
                r_state <= S_F2;
            end
            S_F2: begin
                r_lo    <= m_q;
                r_state <= S_F3;
            end
            S_F3: begin
                r_vx    <= v_q;
                r_state <= S_F4;
            end
            S_F4: begin
                r_vy    <= v_q;
                r_state <= S_EXEC;
            end
            S_EXEC: begin
                r_pc    <= pc2;
                r_state <= S_RESP;
                if (e_fwe) begin
                    r_flag  <= e_fval;
                    r_state <= S_WFLAG;
                end
                unique case (opc)
                    OPC_SYS: begin
                        if (r_lo == LO_RET) begin
                            if (r_sp == '0) begin
                                r_fault <= 1'b1;
                            end else begin
                                r_sp <= sp_m1;
                                r_pc <= r_stack[sp_dec];
                            end
                        end else if (r_lo == LO_CLS) begin
                            r_fvalid <= '0;
                        end
                    end
                    OPC_JP: r_pc <= nnn;
                    OPC_CALL: begin
                        if (r_sp >= SP_W'(STACK_DEPTH)) begin
                            r_fault <= 1'b1;
                        end else begin
                            r_stack[sp_top] <= pc2;
                            r_sp <= r_sp + SP_W'(1);
                            r_pc <= nnn;
                        end
                    end
                    OPC_SEQ:  if (r_vx == r_lo) r_pc <= pc4;
                    OPC_SNE:  if (r_vx != r_lo) r_pc <= pc4;
                    OPC_SER:  if (r_vx == r_vy) r_pc <= pc4;
                    OPC_SNER: if (r_vx != r_vy) r_pc <= pc4;
                    OPC_LDI:  r_idx <= {4'h0, nnn};
                    OPC_JPV:  r_pc <= nnn + ADDR_W'(r_vy);
                    OPC_DRW: begin
                        if (!r_cfg_dw || r_phase == PH_DONE) begin
                            if (r_cfg_dw) r_phase <= PH_FREE;
                            r_i    <= 4'h0;
                            r_coll <= 1'b0;
                            r_state <= (alu == 4'h0) ? S_DEND : S_DM;
                        end else begin
                            r_phase <= PH_WAIT;
                            r_pc    <= r_pc;
                            r_blk   <= 1'b1;
                        end
                    end
                    OPC_KEY: begin
                        if ((r_lo == LO_SKP && key_down) || (r_lo == LO_SKNP && !key_down)) begin
                            r_pc <= pc4;
                        end
                    end
                    OPC_MISC: begin
                        r_i <= 4'h0;
                        case (r_lo)
                            LO_KEY: begin
                                if (r_held == NO_KEY) begin
                                    r_held <= key_any ? {1'b0, key_low} : NO_KEY;
                                    r_blk  <= 1'b1;
                                    r_pc   <= r_pc;
                                end else if (r_keys[r_held[3:0]]) begin
                                    r_blk <= 1'b1;
                                    r_pc  <= r_pc;
                                end else begin
                                    r_held <= NO_KEY;
                                end
                            end
                            LO_SDT: r_delay <= r_vx;
                            LO_SST: r_sound <= r_vx;
                            LO_ADI: r_idx <= idx_sum;
                            LO_FNT: r_idx <= 16'(FONT_START) + 16'(r_vx) * 16'd5;
                            LO_BCD: r_state <= S_BCD;
                            LO_STR: r_state <= S_SRD;
                            LO_LDR: r_state <= S_LRD;
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            S_WFLAG: r_state <= S_RESP;
            S_DM:    r_state <= S_DF;
            S_DF: begin
                r_bits  <= m_q;
                r_state <= S_DW;
            end
            S_DW: begin
                r_coll <= r_coll | (|(f_q & spr_mask));
                r_i    <= r_i + 4'd1;
                r_state <= d_last ? S_DEND : S_DM;
            end
            S_DEND: r_state <= S_RESP;
            S_BCD: begin
                r_i <= r_i + 4'd1;
                if (r_i == 4'd2) r_state <= S_RESP;
            end
            S_SRD: r_state <= S_SWR;
            S_LRD: r_state <= S_LWR;
            S_SWR, S_LWR: begin
                r_i <= r_i + 4'd1;
                if (r_i == xr) begin
                    if (r_cfg_bi) r_idx <= r_idx + 16'(xr) + 16'd1;
                    r_state <= S_RESP;
                end else begin
                    r_state <= (r_state == S_SWR) ? S_SRD : S_LRD;
                end
            end
            S_RESP: begin
                r_o_valid <= 1'b1;
                r_o_row   <= r_res_row;
                r_o_pc    <= r_pc;
                r_o_sound <= r_sound != 8'd0;
                r_o_blk   <= r_blk;
                r_o_fault <= r_fault;
                r_state   <= S_IDLE;
            end
            default: r_state <= S_IDLE;
        endcase

        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_pc       <= ADDR_W'(PROG_START);
            r_idx      <= '0;
            r_sp       <= '0;
            r_delay    <= '0;
            r_sound    <= '0;
            r_phase    <= PH_FREE;
            r_held     <= NO_KEY;
            r_cfg_dw   <= 1'b0;
            r_cfg_lc   <= 1'b0;
            r_cfg_bi   <= 1'b0;
            r_cfg_clip <= 1'b0;
            r_cfg_sh   <= 1'b0;
            r_cfg_jv   <= 1'b0;
            r_vvalid   <= '0;
            r_fvalid   <= '0;
            r_o_valid  <= 1'b0;
        end
    end
endmodule

@@ rtl/c8_ram.sv @@
module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/c8_checker.sv @@
`include "assert_macros.svh"

module c8_checker import c8_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [ADDR_W-1:0] i_out_pc,
    input logic              i_out_blocked,
    input logic              i_out_fault
);
    `C8_ASSERT_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n |=> !i_in_ready, "word accepted during clearing pass")
    `C8_ASSERT(a_ready_needs_room, i_clk, i_rst_n, i_in_ready |-> (!i_out_valid || i_out_ready), "word accepted with result stuck")
    `C8_ASSERT(a_one_cause, i_clk, i_rst_n, i_out_valid |-> !(i_out_blocked && i_out_fault), "blocked and stack fault together")
    `C8_ASSERT(a_result_held, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_pc)), "stalled result changed")
endmodule

bind chip8_cpu_core_unit c8_checker u_c8_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_req.valid),
    .i_in_ready(i_req.ready),
    .i_out_valid(o_rsp.valid),
    .i_out_ready(o_rsp.ready),
    .i_out_pc(o_rsp.prog_counter),
    .i_out_blocked(o_rsp.blocked),
    .i_out_fault(o_rsp.stack_fault)
);

@@ dv/chip8_cpu_core_unit_tb.sv @@
module chip8_cpu_core_unit_tb;
    import c8_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] row_pixels;
        logic [11:0] prog_counter;
        logic        sound_on;
        logic        blocked;
        logic        stack_fault;
    } core_result_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic                 i_cfg_data;

    c8_req_if req_ch();
    c8_rsp_if rsp_ch();

    chip8_cpu_core_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source)
    );

    // Shadow copy of the core's architectural state.
    logic [7:0]  mem_img [MEM_BYTES];
    logic [63:0] frame_img [SCREEN_H];
    logic [7:0]  vreg_img [16];
    logic [15:0] index_img;
    logic [11:0] pc_img;
    logic [11:0] stack_img [STACK_DEPTH];
    int          depth_img;
    logic [7:0]  delay_img;
    logic [7:0]  sound_img;
    logic [1:0]  phase_img;
    logic [4:0]  held_img;
    logic        cfg_img [6];

    core_result_t pending_results[$];
    int           fail_count;
    int           burst_left;
    int           idle_mode;
    int           stall_mode;
    logic         hold_req;
    int           hold_cnt;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic reset_image();
        foreach (mem_img[a]) mem_img[a] = 8'h00;
        for (int k = 0; k < FONT_BYTES; k++) mem_img[FONT_START + k] = HEX_FONT[k];
        foreach (frame_img[r]) frame_img[r] = '0;
        foreach (vreg_img[r]) vreg_img[r] = 8'h00;
        foreach (stack_img[r]) stack_img[r] = '0;
        foreach (cfg_img[r]) cfg_img[r] = 1'b0;
        index_img = '0;
        pc_img = 12'(PROG_START);
        depth_img = 0;
        delay_img = '0;
        sound_img = '0;
        phase_img = PH_FREE;
        held_img = NO_KEY;
    endtask

    task automatic draw_sprite(input logic [3:0] xr, input logic [3:0] yr, input logic [3:0] n);
        int x0;
        int y0;
        logic [7:0] bits;
        logic [63:0] m;
        int row;
        int col;
        x0 = vreg_img[xr] % SCREEN_W;
        y0 = vreg_img[yr] % SCREEN_H;
        vreg_img[FLAG_REG] = 8'h00;
        for (int i = 0; i < n; i++) begin
            bits = mem_img[12'(index_img + i)];
            row = (y0 + i) % SCREEN_H;
            for (int j = 0; j < 8; j++) begin
                col = (x0 + j) % SCREEN_W;
                m = 64'd1 << (63 - col);
                if (bits[7-j]) begin
                    if (frame_img[row] & m) vreg_img[FLAG_REG] = 8'h01;
                    frame_img[row] ^= m;
                end
                if (cfg_img[CFG_CLIP] && x0 + j == SCREEN_W - 1) break;
            end
            if (cfg_img[CFG_CLIP] && y0 + i == SCREEN_H - 1) break;
        end
    endtask

    task automatic run_instruction(input logic [15:0] keys, input logic [7:0] rnd,
                                   output logic blk, output logic flt);
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  n;
        logic [11:0] nnn;
        logic [7:0]  vx;
        logic [7:0]  vy;
        logic [7:0]  s;
        logic        down;
        hi = mem_img[pc_img];
        lo = mem_img[12'(pc_img + 1)];
        x = hi[3:0];
        y = lo[7:4];
        n = lo[3:0];
        nnn = {x, lo};
        blk = 1'b0;
        flt = 1'b0;
        pc_img = pc_img + 12'd2;
        vx = vreg_img[x];
        vy = vreg_img[y];
        case (hi[7:4])
            OPC_SYS: begin
                if (lo == LO_RET) begin
                    if (depth_img == 0) flt = 1'b1;
                    else begin
                        depth_img--;
                        pc_img = stack_img[depth_img];
                    end
                end else if (lo == LO_CLS) begin
                    foreach (frame_img[r]) frame_img[r] = '0;
                end
            end
            OPC_JP: pc_img = nnn;
            OPC_CALL: begin
                if (depth_img >= STACK_DEPTH) flt = 1'b1;
                else begin
                    stack_img[depth_img] = pc_img;
                    depth_img++;
                    pc_img = nnn;
                end
            end
            OPC_SEQ: if (vx == lo) pc_img = pc_img + 12'd2;
            OPC_SNE: if (vx != lo) pc_img = pc_img + 12'd2;
            OPC_SER: if (vx == vy) pc_img = pc_img + 12'd2;
            OPC_LD: vreg_img[x] = lo;
            OPC_ADD: vreg_img[x] = vx + lo;
            OPC_ALU: begin
                case (n)
                    ALU_MOV: vreg_img[x] = vy;
                    ALU_OR: begin
                        vreg_img[x] = vx | vy;
                        if (cfg_img[CFG_LOGIC_CLEARS]) vreg_img[FLAG_REG] = 8'h00;
                    end
                    ALU_AND: begin
                        vreg_img[x] = vx & vy;
                        if (cfg_img[CFG_LOGIC_CLEARS]) vreg_img[FLAG_REG] = 8'h00;
                    end
                    ALU_XOR: begin
                        vreg_img[x] = vx ^ vy;
                        if (cfg_img[CFG_LOGIC_CLEARS]) vreg_img[FLAG_REG] = 8'h00;
                    end
                    ALU_ADD: begin
                        vreg_img[x] = vx + vy;
                        vreg_img[FLAG_REG] = (9'(vx) + 9'(vy) > 9'hFF) ? 8'h01 : 8'h00;
                    end
                    ALU_SUB: begin
                        vreg_img[x] = vx - vy;
                        vreg_img[FLAG_REG] = (vx >= vy) ? 8'h01 : 8'h00;
                    end
                    ALU_SHR: begin
                        s = cfg_img[CFG_SHIFT_VX] ? vx : vy;
                        vreg_img[x] = s >> 1;
                        vreg_img[FLAG_REG] = {7'd0, s[0]};
                    end
                    ALU_SBN: begin
                        vreg_img[x] = vy - vx;
                        vreg_img[FLAG_REG] = (vy >= vx) ? 8'h01 : 8'h00;
                    end
                    ALU_SHL: begin
                        s = cfg_img[CFG_SHIFT_VX] ? vx : vy;
                        vreg_img[x] = s << 1;
                        vreg_img[FLAG_REG] = {7'd0, s[7]};
                    end
                    default: ;
                endcase
            end
            OPC_SNER: if (vx != vy) pc_img = pc_img + 12'd2;
            OPC_LDI: index_img = {4'd0, nnn};
            OPC_JPV: pc_img = nnn + (cfg_img[CFG_JUMP_VX] ? vx : vreg_img[0]);
            OPC_RND: vreg_img[x] = rnd & lo;
            OPC_DRW: begin
                if (!cfg_img[CFG_DISPLAY_WAIT]) draw_sprite(x, y, n);
                else if (phase_img == PH_DONE) begin
                    phase_img = PH_FREE;
                    draw_sprite(x, y, n);
                end else begin
                    phase_img = PH_WAIT;
                    pc_img = pc_img - 12'd2;
                    blk = 1'b1;
                end
            end
            OPC_KEY: begin
                down = vx < 16 && keys[vx[3:0]];
                if (lo == LO_SKP && down) pc_img = pc_img + 12'd2;
                if (lo == LO_SKNP && !down) pc_img = pc_img + 12'd2;
            end
            OPC_MISC: begin
                case (lo)
                    LO_KEY: begin
                        if (held_img == NO_KEY) begin
                            for (int i = 0; i < 16; i++) begin
                                if (keys[i]) begin
                                    held_img = 5'(i);
                                    break;
                                end
                            end
                            blk = 1'b1;
                        end else if (keys[held_img[3:0]]) begin
                            blk = 1'b1;
                        end else begin
                            vreg_img[x] = {3'd0, held_img};
                            held_img = NO_KEY;
                        end
                        if (blk) pc_img = pc_img - 12'd2;
                    end
                    LO_GDT: vreg_img[x] = delay_img;
                    LO_SDT: delay_img = vx;
                    LO_SST: sound_img = vx;
                    LO_ADI: begin
                        index_img = index_img + vx;
                        if (index_img > 16'h1000) vreg_img[FLAG_REG] = 8'h01;
                    end
                    LO_FNT: index_img = 16'(FONT_START + vx * 5);
                    LO_BCD: begin
                        mem_img[12'(index_img)] = vx / 100;
                        mem_img[12'(index_img + 1)] = (vx / 10) % 10;
                        mem_img[12'(index_img + 2)] = vx % 10;
                    end
                    LO_STR: begin
                        for (int i = 0; i <= x; i++) mem_img[12'(index_img + i)] = vreg_img[i];
                        if (cfg_img[CFG_BULK_INDEX]) index_img = index_img + x + 16'd1;
                    end
                    LO_LDR: begin
                        for (int i = 0; i <= x; i++) vreg_img[i] = mem_img[12'(index_img + i)];
                        if (cfg_img[CFG_BULK_INDEX]) index_img = index_img + x + 16'd1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endtask

    task automatic predict_word(input logic [2:0] op, input logic [11:0] addr,
                                input logic [7:0] data, input logic [15:0] keys,
                                input logic [7:0] rnd, input logic [4:0] row);
        core_result_t res;
        logic blk;
        logic flt;
        res.row_pixels = '0;
        blk = 1'b0;
        flt = 1'b0;
        case (op)
            OP_EXEC: run_instruction(keys, rnd, blk, flt);
            OP_TICK: begin
                if (delay_img > 0) delay_img--;
                if (sound_img > 0) sound_img--;
            end
            OP_LOAD: mem_img[addr] = data;
            OP_REFRESH: begin
                if (cfg_img[CFG_DISPLAY_WAIT] && phase_img == PH_WAIT) phase_img = PH_DONE;
            end
            OP_ROW: res.row_pixels = frame_img[row];
            default: ;
        endcase
        res.prog_counter = pc_img;
        res.sound_on = sound_img != 0;
        res.blocked = blk;
        res.stack_fault = flt;
        pending_results.push_back(res);
    endtask

    task automatic send_word(input logic [2:0] op, input logic [11:0] addr,
                             input logic [7:0] data, input logic [15:0] keys,
                             input logic [7:0] rnd, input logic [4:0] row);
        if (idle_mode != 0 && burst_left <= 0) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        req_ch.valid = 1'b1;
        req_ch.op = op;
        req_ch.load_addr = addr;
        req_ch.load_data = data;
        req_ch.keypad = keys;
        req_ch.rand_byte = rnd;
        req_ch.row_sel = row;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_word(op, addr, data, keys, rnd, row);
        burst_left--;
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_keys();
        if ($urandom_range(0, 1)) return 16'h0000;
        return 16'($urandom);
    endfunction

    // Places an instruction at the predicted PC and runs it.
    task automatic run_at_pc(input logic [15:0] insn, input logic [15:0] keys);
        send_word(OP_LOAD, pc_img, insn[15:8], 16'($urandom), 8'($urandom), 5'($urandom));
        send_word(OP_LOAD, pc_img + 12'd1, insn[7:0], 16'($urandom), 8'($urandom),
                  5'($urandom));
        send_word(OP_EXEC, 12'($urandom), 8'($urandom), keys, 8'($urandom), 5'($urandom));
    endtask

    function automatic logic [15:0] random_insn();
        logic [3:0] cls;
        logic [3:0] x;
        logic [7:0] lo;
        logic [7:0] misc_lo [14];
        misc_lo = '{LO_GDT, LO_KEY, LO_SDT, LO_SST, LO_ADI, LO_FNT, LO_BCD, LO_STR,
                    LO_LDR, LO_LDR, LO_STR, LO_ADI, LO_SDT, 8'h00};
        cls = 4'($urandom);
        x = 4'($urandom);
        lo = 8'($urandom);
        case (cls)
            OPC_SYS: begin
                case ($urandom_range(0, 3))
                    0, 1: lo = LO_RET;
                    2: lo = LO_CLS;
                    default: ;
                endcase
            end
            OPC_ALU: begin
                if ($urandom_range(0, 7) != 0) lo[3:0] = ($urandom_range(0, 8) == 8) ? ALU_SHL
                                                       : 4'($urandom_range(0, 7));
            end
            OPC_KEY: begin
                case ($urandom_range(0, 2))
                    0: lo = LO_SKP;
                    1: lo = LO_SKNP;
                    default: ;
                endcase
            end
            OPC_MISC: begin
                lo = misc_lo[$urandom_range(0, 13)];
                if (lo == 8'h00) lo = 8'($urandom);
            end
            default: ;
        endcase
        return {cls, x, lo};
    endfunction

    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        cfg_img[idx] = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_quirks(input logic [5:0] q);
        wait_idle();
        for (int i = 0; i < 6; i++) write_cfg(CFG_IDX_W'(i), q[i]);
    endtask

    task automatic random_traffic(input int count);
        int sent;
        int kind;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                run_at_pc(random_insn(), pick_keys());
                sent += 3;
            end else if (kind < 75) begin
                // A call chain deep enough to overflow, then unwinding returns.
                for (int i = 0; i < 18; i++) run_at_pc({OPC_CALL, 12'(pc_img + 2)}, 16'h0);
                for (int i = 0; i < 19; i++) run_at_pc({OPC_SYS, 4'($urandom), LO_RET}, 16'h0);
                sent += 111;
            end else if (kind < 83) begin
                send_word(OP_REFRESH, 12'($urandom), 8'($urandom), 16'($urandom),
                          8'($urandom), 5'($urandom));
                sent++;
            end else if (kind < 88) begin
                send_word(OP_TICK, 12'($urandom), 8'($urandom), 16'($urandom),
                          8'($urandom), 5'($urandom));
                sent++;
            end else if (kind < 94) begin
                send_word(OP_ROW, 12'($urandom), 8'($urandom), 16'($urandom),
                          8'($urandom), 5'($urandom));
                sent++;
            end else if (kind < 98) begin
                send_word(OP_LOAD, 12'($urandom), 8'($urandom), 16'($urandom),
                          8'($urandom), 5'($urandom));
                sent++;
            end else begin
                send_word(3'($urandom_range(5, 7)), 12'($urandom), 8'($urandom),
                          16'($urandom), 8'($urandom), 5'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        run_at_pc({OPC_LD, 4'h0, 8'hFF}, 16'h0);
        run_at_pc({OPC_ADD, 4'h0, 8'h01}, 16'h0);
        run_at_pc({OPC_MISC, 4'h0, LO_FNT}, 16'h0);
        run_at_pc({OPC_DRW, 4'h0, 4'h0, 4'h5}, 16'h0);
        run_at_pc({OPC_SYS, 4'h0, LO_RET}, 16'h0);
        run_at_pc({OPC_MISC, 4'h1, LO_KEY}, 16'h8004);
        run_at_pc({OPC_MISC, 4'h1, LO_KEY}, 16'h0000);
        send_word(OP_ROW, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF, 5'd0);
        send_word(OP_TICK, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd31);
        send_word(3'd7, 12'h000, 8'h00, 16'h0000, 8'h00, 5'd0);
    endtask

    task automatic test_quirk_sets();
        logic [5:0] sets [5];
        sets = '{6'h3F, 6'h00, 6'($urandom), 6'($urandom), 6'h01};
        foreach (sets[s]) begin
            set_quirks(sets[s]);
            idle_mode = s % 2;
            stall_mode = (s + 1) % 3;
            random_traffic(330);
        end
    endtask

    task automatic test_backpressure();
        idle_mode = 0;
        hold_req = 1'b1;
        random_traffic(60);
    endtask

    // Receiver side: a stall pattern, with an occasional long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_req) begin
            hold_req <= 1'b0;
            hold_cnt <= 300;
            rsp_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= $urandom_range(0, 3) != 0;
                default: rsp_ch.ready <= $urandom_range(0, 1);
            endcase
        end
    end

    always @(posedge i_clk) begin
        core_result_t want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected word", rsp_ch.prog_counter, '0);
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.row_pixels !== want.row_pixels)
                    report("row_pixels", rsp_ch.row_pixels, want.row_pixels);
                if (rsp_ch.prog_counter !== want.prog_counter)
                    report("prog_counter", rsp_ch.prog_counter, want.prog_counter);
                if (rsp_ch.sound_on !== want.sound_on)
                    report("sound_on", rsp_ch.sound_on, want.sound_on);
                if (rsp_ch.blocked !== want.blocked)
                    report("blocked", rsp_ch.blocked, want.blocked);
                if (rsp_ch.stack_fault !== want.stack_fault)
                    report("stack_fault", rsp_ch.stack_fault, want.stack_fault);
            end
        end
    end

    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        fail_count = 0;
        burst_left = 0;
        idle_mode = 1;
        stall_mode = 1;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op = OP_TICK;
        req_ch.load_addr = '0;
        req_ch.load_data = '0;
        req_ch.keypad = '0;
        req_ch.rand_byte = '0;
        req_ch.row_sel = '0;
        reset_image();
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_quirk_sets();
        test_backpressure();
        wait_idle();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
